// ----- rtl/srlu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlu_pkg: shared types and constants for the sparse row lookup/update block
// word layouts, opcodes, status codes, register indexes and sequencer states
// ----------------------------------------------------------------------------
package srlu_pkg;

  // field widths of the words
  localparam int OPCODE_W = 2;
  localparam int ROW_W    = 11;
  localparam int COL_W    = 16;
  localparam int SLOT_W   = 12;
  localparam int PTR_W    = 13;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int NROWS_W  = 11;
  localparam int NCOLS_W  = 17;
  localparam int CFG_W    = 17;

  // column limit; the 16-bit column field always stays below it
  localparam longint unsigned MAX_COLS = 64'd65536;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_PTR   = 2'd0,
    OP_LOAD_ENTRY = 2'd1,
    OP_GET        = 2'd2,
    OP_SET        = 2'd3
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIMS    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

  localparam logic CFG_NUM_ROWS = 1'b0;
  localparam logic CFG_NUM_COLS = 1'b1;

  typedef struct packed {
    op_t                opcode;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [SLOT_W-1:0]  slot;
    logic [PTR_W-1:0]   start_pointer;
    logic [VALUE_W-1:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LO,
    S_HI,
    S_SRCH,
    S_CMP,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/srlu_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlu_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle, contents undefined at reset
// ----------------------------------------------------------------------------
module srlu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sparse_row_lookup_update_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_row_lookup_update_top: element get/set on a csr sparse matrix
// row pointer, column index and value stores with a binary search sequencer
// ----------------------------------------------------------------------------
//  channel  direction  handshake          word
//  in_      input      in_valid/in_ready  srlu_pkg::in_word_t
//  out_     output     out_valid/out_ready srlu_pkg::out_word_t
//  cfg_     input      cfg_we             cfg_index selects num_rows/num_cols
//
//  loads and dims fails step through exec and done from accept to result register
//  get/set: exec, lo, hi, then srch and cmp per probe of the shared compare unit, a last srch on a miss
//  one word in flight; in_ready is high only while the sequencer is idle
//  the result register lets a new word in; a waiting result holds the next in done
//  synchronous active-low reset clears control and config; stores are not cleared
// ----------------------------------------------------------------------------
module sparse_row_lookup_update_top #(
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_ENTRIES = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire srlu_pkg::in_word_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output srlu_pkg::out_word_t              out_data,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [srlu_pkg::CFG_W-1:0]  cfg_data
);

  // row store holds MAX_ROWS+1 pointers, entry index and span bound widths
  localparam int ROW_DEPTH = MAX_ROWS + 1;
  localparam int RW = $clog2(ROW_DEPTH);
  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int PW = $clog2(MAX_ENTRIES + 1);

  // configuration
  logic [srlu_pkg::NROWS_W-1:0] num_rows_r;
  logic [srlu_pkg::NCOLS_W-1:0] num_cols_r;

  // sequencer and datapath registers
  srlu_pkg::state_t    state_r, state_nxt;
  srlu_pkg::in_word_t  item_r, item_nxt;
  logic [PW-1:0]       lo_r, lo_nxt;
  logic [PW-1:0]       hi_r, hi_nxt;
  logic [EW-1:0]       mid_r, mid_nxt;
  srlu_pkg::out_word_t res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  srlu_pkg::out_word_t out_data_r, out_data_nxt;

  // ram ports
  logic                       row_we, row_re;
  logic [RW-1:0]              row_waddr, row_raddr;
  logic [srlu_pkg::PTR_W-1:0] row_rdata;
  logic                       col_we, val_we, ent_re;
  logic [EW-1:0]              ent_waddr, ent_raddr;
  logic [srlu_pkg::COL_W-1:0] col_rdata;
  logic [srlu_pkg::VALUE_W-1:0] val_rdata;

  // address and bound helpers
  logic [31:0]   row_w, row_p1_w, slot_w, ptr_w;
  logic [RW-1:0] row_addr, row_addr_p1;
  logic [EW-1:0] slot_addr;
  logic [PW-1:0] ptr_clamped;
  logic [PW-1:0] span, mid_sum, mid_p1;
  logic [EW-1:0] mid_calc;
  logic          row_ok_ld, slot_ok, dims_bad;

  assign row_w       = 32'(item_r.row);
  assign row_p1_w    = row_w + 32'd1;
  assign row_addr    = row_w[RW-1:0];
  assign row_addr_p1 = row_p1_w[RW-1:0];
  assign slot_w      = 32'(item_r.slot);
  assign slot_addr   = slot_w[EW-1:0];
  assign row_ok_ld   = (row_w <= 32'(MAX_ROWS));
  assign slot_ok     = (slot_w < 32'(MAX_ENTRIES));

  // rows at or past the store count as out of range too
  assign dims_bad = (row_w >= 32'(num_rows_r)) || (row_w >= 32'(MAX_ROWS)) ||
                    (64'(item_r.col) >= 64'(num_cols_r)) ||
                    (64'(item_r.col) >= srlu_pkg::MAX_COLS);

  // span ends saturate at the entry store size
  assign ptr_w       = 32'(row_rdata);
  assign ptr_clamped = (ptr_w > 32'(MAX_ENTRIES)) ? PW'(MAX_ENTRIES) : ptr_w[PW-1:0];

  // shared probe unit: midpoint of the live span
  assign span     = hi_r - lo_r;
  assign mid_sum  = lo_r + (span >> 1);
  assign mid_calc = mid_sum[EW-1:0];
  assign mid_p1   = PW'(mid_r) + PW'(1);

  assign in_ready  = (state_r == srlu_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= '0;
      num_cols_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        srlu_pkg::CFG_NUM_ROWS: num_rows_r <= cfg_data[srlu_pkg::NROWS_W-1:0];
        srlu_pkg::CFG_NUM_COLS: num_cols_r <= cfg_data[srlu_pkg::NCOLS_W-1:0];
        default: ;
      endcase
    end
  end

  // state register and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srlu_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    row_we        = 1'b0;
    row_waddr     = row_addr;
    row_re        = 1'b0;
    row_raddr     = row_addr;
    col_we        = 1'b0;
    val_we        = 1'b0;
    ent_waddr     = slot_addr;
    ent_re        = 1'b0;
    ent_raddr     = mid_calc;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      srlu_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = srlu_pkg::S_EXEC;
        end
      end
      srlu_pkg::S_EXEC: begin
        res_nxt.status     = srlu_pkg::ST_OK;
        res_nxt.read_value = '0;
        case (item_r.opcode)
          srlu_pkg::OP_LOAD_PTR: begin
            row_we    = row_ok_ld;
            state_nxt = srlu_pkg::S_DONE;
          end
          srlu_pkg::OP_LOAD_ENTRY: begin
            col_we    = slot_ok;
            val_we    = slot_ok;
            state_nxt = srlu_pkg::S_DONE;
          end
          default: begin
            if (dims_bad) begin
              res_nxt.status = srlu_pkg::ST_DIMS;
              state_nxt      = srlu_pkg::S_DONE;
            end else begin
              row_re    = 1'b1;
              state_nxt = srlu_pkg::S_LO;
            end
          end
        endcase
      end
      srlu_pkg::S_LO: begin
        lo_nxt    = ptr_clamped;
        row_re    = 1'b1;
        row_raddr = row_addr_p1;
        state_nxt = srlu_pkg::S_HI;
      end
      srlu_pkg::S_HI: begin
        hi_nxt    = ptr_clamped;
        state_nxt = srlu_pkg::S_SRCH;
      end
      srlu_pkg::S_SRCH: begin
        if (lo_r < hi_r) begin
          ent_re    = 1'b1;
          mid_nxt   = mid_calc;
          state_nxt = srlu_pkg::S_CMP;
        end else begin
          // miss: a set of a nonzero word (either zero sign allowed) fails
          if ((item_r.opcode == srlu_pkg::OP_SET) &&
              (item_r.write_value[srlu_pkg::VALUE_W-2:0] != '0)) begin
            res_nxt.status = srlu_pkg::ST_MISSING;
          end
          state_nxt = srlu_pkg::S_DONE;
        end
      end
      srlu_pkg::S_CMP: begin
        if (col_rdata == item_r.col) begin
          if (item_r.opcode == srlu_pkg::OP_GET) begin
            res_nxt.read_value = val_rdata;
          end else begin
            val_we    = 1'b1;
            ent_waddr = mid_r;
          end
          state_nxt = srlu_pkg::S_DONE;
        end else if (col_rdata < item_r.col) begin
          lo_nxt    = mid_p1;
          state_nxt = srlu_pkg::S_SRCH;
        end else begin
          hi_nxt    = PW'(mid_r);
          state_nxt = srlu_pkg::S_SRCH;
        end
      end
      srlu_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = srlu_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = srlu_pkg::S_IDLE;
      end
    endcase
  end

  // row start pointers
  srlu_ram #(
    .WIDTH (srlu_pkg::PTR_W),
    .DEPTH (ROW_DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (item_r.start_pointer),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // column index of each entry
  srlu_ram #(
    .WIDTH (srlu_pkg::COL_W),
    .DEPTH (MAX_ENTRIES)
  ) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (ent_waddr),
    .wdata (item_r.col),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (col_rdata)
  );

  // value word of each entry
  srlu_ram #(
    .WIDTH (srlu_pkg::VALUE_W),
    .DEPTH (MAX_ENTRIES)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (ent_waddr),
    .wdata (item_r.write_value),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (val_rdata)
  );

  // an accepted word always starts execution next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == srlu_pkg::S_EXEC)
    else $error("accepted word did not start execution");

  // span bounds never pass the entry store size while searching
  a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == srlu_pkg::S_SRCH |-> (hi_r <= PW'(MAX_ENTRIES)) && (lo_r <= PW'(MAX_ENTRIES)))
    else $error("search span out of store range");

  // probe position lies inside the live span
  a_probe_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == srlu_pkg::S_CMP |-> (PW'(mid_r) >= lo_r) && (PW'(mid_r) < hi_r))
    else $error("probe outside search span");

  // a finished word reaches the result register once it is free
  a_done_lands: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == srlu_pkg::S_DONE && (!out_valid_r || out_ready) |=> out_valid_r)
    else $error("result not delivered to output register");

endmodule
`default_nettype wire
